[hdl/acp_pkg.sv]
// Shared types and constants for the CSI cursor and color parser.
// No dependencies; used by acp_ctrl, acp_dp, the top level and acp_checker.
package acp_pkg;

  localparam int unsigned PV_W    = 14;          // stored parameter width
  localparam int unsigned CH_W    = 8;
  localparam int unsigned COLOR_W = 3;
  localparam int unsigned ROW_O_W = 5;           // result row field width
  localparam int unsigned COL_O_W = 7;           // result column field width
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [PV_W-1:0] PARAM_CAP = 14'd9999;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_FG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_BG = 2'd1;

  localparam logic [COLOR_W-1:0] FG_RESET = 3'd7;
  localparam logic [COLOR_W-1:0] BG_RESET = 3'd0;

  // character codes
  localparam logic [CH_W-1:0] CH_0      = 8'h30;
  localparam logic [CH_W-1:0] CH_9      = 8'h39;
  localparam logic [CH_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CH_W-1:0] CH_UP     = 8'h41;   // A
  localparam logic [CH_W-1:0] CH_DOWN   = 8'h42;   // B
  localparam logic [CH_W-1:0] CH_RIGHT  = 8'h43;   // C
  localparam logic [CH_W-1:0] CH_LEFT   = 8'h44;   // D
  localparam logic [CH_W-1:0] CH_POS    = 8'h48;   // H
  localparam logic [CH_W-1:0] CH_CLEAR  = 8'h4A;   // J
  localparam logic [CH_W-1:0] CH_POS_F  = 8'h66;   // f
  localparam logic [CH_W-1:0] CH_SGR    = 8'h6D;   // m
  localparam logic [CH_W-1:0] CH_SAVE   = 8'h73;   // s
  localparam logic [CH_W-1:0] CH_RESTORE= 8'h75;   // u

  // SGR codes
  localparam logic [PV_W-1:0] SGR_RESET   = 14'd0;
  localparam logic [PV_W-1:0] SGR_REVERSE = 14'd7;
  localparam logic [PV_W-1:0] SGR_CONCEAL = 14'd8;
  localparam logic [PV_W-1:0] SGR_FG_LO   = 14'd30;
  localparam logic [PV_W-1:0] SGR_FG_HI   = 14'd37;
  localparam logic [PV_W-1:0] SGR_BG_LO   = 14'd40;
  localparam logic [PV_W-1:0] SGR_BG_HI   = 14'd47;

  typedef struct packed {
    logic capture;   // latch the input word
    logic exec;      // run the character's action
    logic walk;      // one SGR slot step
    logic load_out;  // move result into the output register
  } acp_cmd_t;

  typedef struct packed {
    logic need_walk;
    logic walk_last;
    logic out_free;
  } acp_sts_t;

endpackage

[hdl/acp_ctrl.sv]
// Sequencer for the CSI parser: capture, execute, SGR walk, finish.
// Depends on acp_pkg; drives acp_dp through acp_cmd_t.
module acp_ctrl
  import acp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  acp_sts_t sts,
  output acp_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_stall = (state_r != S_IDLE) || !rst_n;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.need_walk ? S_WALK : S_FIN;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

[hdl/acp_dp.sv]
// Datapath for the CSI parser: parameter slots, cursor, colors, output register.
// Depends on acp_pkg; commanded by acp_ctrl.
module acp_dp
  import acp_pkg::*;
#(
  parameter int ROWS       = 25,
  parameter int COLS       = 80,
  parameter int MAX_PARAMS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  acp_cmd_t             cmd,
  output acp_sts_t             sts,
  input  logic [CH_W-1:0]      in_ch,
  input  logic                 in_seq_start,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_wdata,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_seq_done,
  output logic [ROW_O_W-1:0]   out_cursor_row_out,
  output logic [COL_O_W-1:0]   out_cursor_col_out,
  output logic [COLOR_W-1:0]   out_fg_color,
  output logic [COLOR_W-1:0]   out_bg_color,
  output logic                 out_clear_screen
);

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);
  localparam int SW = $clog2(MAX_PARAMS);
  localparam int AW = PV_W + 1;      // cursor arithmetic width
  localparam logic [AW-1:0] ROWS_X = AW'(ROWS);
  localparam logic [AW-1:0] COLS_X = AW'(COLS);
  localparam logic [AW-1:0] ROW_LAST_X = AW'(ROWS - 1);
  localparam logic [AW-1:0] COL_LAST_X = AW'(COLS - 1);
  localparam logic [SW-1:0] SLOT_LAST = SW'(MAX_PARAMS - 1);

  // input word
  logic [CH_W-1:0] ch_r;
  logic            start_r;

  // parameter slots
  logic [PV_W-1:0]       vals_r [MAX_PARAMS];
  logic [MAX_PARAMS-1:0] present_r, present_nxt;
  logic [SW-1:0]         slot_r, slot_nxt;
  logic [SW-1:0]         walk_idx_r, walk_idx_nxt;

  // screen state
  logic [RW-1:0]      row_r, row_nxt, srow_r, srow_nxt;
  logic [CW-1:0]      col_r, col_nxt, scol_r, scol_nxt;
  logic [COLOR_W-1:0] fg_r, fg_nxt, bg_r, bg_nxt;
  logic [COLOR_W-1:0] dfg_r, dbg_r;
  logic               pend_done_r, pend_done_nxt;
  logic               pend_clr_r, pend_clr_nxt;

  // output register
  logic               out_valid_r;
  logic               o_done_r, o_clr_r;
  logic [RW-1:0]      o_row_r;
  logic [CW-1:0]      o_col_r;
  logic [COLOR_W-1:0] o_fg_r, o_bg_r;

  // combinational
  logic [SW-1:0]         eff_slot, slot_inc, rd_idx;
  logic [MAX_PARAMS-1:0] eff_present;
  logic [PV_W-1:0]       rd_val, p0, p1, n, wdata;
  logic [3:0]            digit;
  logic                  is_digit, val_we;
  logic [PV_W+3:0]       acc;
  logic [PV_W-1:0]       acc_sat;
  logic [AW-1:0]         row_x, col_x, n_x, sum, pos0, pos1;
  logic [PV_W-1:0]       code_fg, code_bg;
  logic [RW+ROW_O_W-1:0] row_ext;
  logic [CW+COL_O_W-1:0] col_ext;

  always_comb begin
    eff_slot    = start_r ? '0 : slot_r;
    eff_present = start_r ? '0 : present_r;
    slot_inc    = eff_slot + SW'(1);
    rd_idx      = cmd.walk ? walk_idx_r : eff_slot;
    rd_val      = vals_r[rd_idx];
    p0          = vals_r[0];
    p1          = vals_r[1];
    is_digit    = (ch_r >= CH_0) && (ch_r <= CH_9);
    digit       = ch_r[3:0];
    acc         = (PV_W+4)'({rd_val, 3'b000}) + (PV_W+4)'({rd_val, 1'b0})
                + (PV_W+4)'(digit);
    acc_sat     = (acc > (PV_W+4)'(PARAM_CAP)) ? PARAM_CAP : acc[PV_W-1:0];
    n           = eff_present[0] ? p0 : PV_W'(1);
    n_x         = AW'(n);
    row_x       = AW'(row_r);
    col_x       = AW'(col_r);
    pos0        = (p0 == '0) ? '0 : AW'(p0) - AW'(1);
    pos1        = (p1 == '0) ? '0 : AW'(p1) - AW'(1);
    sum         = '0;
    code_fg     = rd_val - SGR_FG_LO;
    code_bg     = rd_val - SGR_BG_LO;

    present_nxt   = present_r;
    slot_nxt      = slot_r;
    walk_idx_nxt  = walk_idx_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    srow_nxt      = srow_r;
    scol_nxt      = scol_r;
    fg_nxt        = fg_r;
    bg_nxt        = bg_r;
    pend_done_nxt = pend_done_r;
    pend_clr_nxt  = pend_clr_r;
    val_we        = 1'b0;
    wdata         = eff_present[eff_slot] ? acc_sat : PV_W'(digit);

    if (cmd.exec) begin
      present_nxt   = eff_present;
      slot_nxt      = eff_slot;
      walk_idx_nxt  = '0;
      pend_done_nxt = 1'b1;
      pend_clr_nxt  = 1'b0;
      if (is_digit) begin
        val_we                = 1'b1;
        present_nxt[eff_slot] = 1'b1;
        pend_done_nxt         = 1'b0;
      end else begin
        case (ch_r)
          CH_SEMI: begin
            pend_done_nxt = 1'b0;
            if (eff_slot != SLOT_LAST) begin
              slot_nxt              = slot_inc;
              present_nxt[slot_inc] = 1'b0;
            end
          end
          CH_POS, CH_POS_F: begin
            if (!eff_present[0]) begin
              row_nxt = '0;
              col_nxt = '0;
            end else begin
              row_nxt = (pos0 >= ROWS_X) ? RW'(ROW_LAST_X) : RW'(pos0);
              if (!eff_present[1])     col_nxt = '0;
              else if (pos1 >= COLS_X) col_nxt = CW'(COL_LAST_X);
              else                     col_nxt = CW'(pos1);
            end
          end
          CH_UP: begin
            row_nxt = (row_x > n_x) ? RW'(row_x - n_x) : '0;
          end
          CH_DOWN: begin
            sum     = row_x + n_x;
            row_nxt = (sum >= ROWS_X) ? RW'(ROW_LAST_X) : RW'(sum);
          end
          CH_RIGHT: begin
            sum     = col_x + n_x;
            col_nxt = (sum >= COLS_X) ? CW'(COL_LAST_X) : CW'(sum);
          end
          CH_LEFT: begin
            col_nxt = (col_x > n_x) ? CW'(col_x - n_x) : '0;
          end
          CH_SAVE: begin
            srow_nxt = row_r;
            scol_nxt = col_r;
          end
          CH_RESTORE: begin
            row_nxt = srow_r;
            col_nxt = scol_r;
          end
          CH_CLEAR: begin
            row_nxt      = '0;
            col_nxt      = '0;
            pend_clr_nxt = 1'b1;
          end
          CH_SGR: begin
            // absent first slot: plain reset; otherwise the walk does the work
            if (!eff_present[0]) begin
              fg_nxt = dfg_r;
              bg_nxt = dbg_r;
            end
          end
          default: ;
        endcase
      end
    end

    // one slot per cycle; stops at the first absent slot or the current slot
    if (cmd.walk) begin
      walk_idx_nxt = walk_idx_r + SW'(1);
      if (present_r[walk_idx_r]) begin
        if (rd_val == SGR_RESET) begin
          fg_nxt = dfg_r;
          bg_nxt = dbg_r;
        end else if (rd_val == SGR_REVERSE) begin
          fg_nxt = bg_r;
          bg_nxt = fg_r;
        end else if (rd_val == SGR_CONCEAL) begin
          fg_nxt = bg_r;
        end else if (rd_val inside {[SGR_FG_LO:SGR_FG_HI]}) begin
          fg_nxt = code_fg[COLOR_W-1:0];
        end else if (rd_val inside {[SGR_BG_LO:SGR_BG_HI]}) begin
          bg_nxt = code_bg[COLOR_W-1:0];
        end
      end
    end

    sts.need_walk = (ch_r == CH_SGR) && eff_present[0];
    sts.walk_last = !present_r[walk_idx_r] || (walk_idx_r == slot_r);
    sts.out_free  = !out_valid_r || !out_stall;

    row_ext = (RW+ROW_O_W)'(o_row_r);
    col_ext = (CW+COL_O_W)'(o_col_r);
  end

  // payload and slot storage
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ch_r    <= in_ch;
      start_r <= in_seq_start;
    end
    if (val_we) vals_r[eff_slot] <= wdata;
    if (cmd.load_out) begin
      o_done_r <= pend_done_r;
      o_clr_r  <= pend_clr_r;
      o_row_r  <= row_r;
      o_col_r  <= col_r;
      o_fg_r   <= fg_r;
      o_bg_r   <= bg_r;
    end
    walk_idx_r    <= walk_idx_nxt;
    pend_done_r   <= pend_done_nxt;
    pend_clr_r    <= pend_clr_nxt;
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r   <= '0;
      slot_r      <= '0;
      row_r       <= '0;
      col_r       <= '0;
      srow_r      <= '0;
      scol_r      <= '0;
      fg_r        <= FG_RESET;
      bg_r        <= BG_RESET;
      dfg_r       <= FG_RESET;
      dbg_r       <= BG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      present_r <= present_nxt;
      slot_r    <= slot_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      srow_r    <= srow_nxt;
      scol_r    <= scol_nxt;
      fg_r      <= fg_nxt;
      bg_r      <= bg_nxt;
      if (cfg_we && cfg_index == CFG_DEFAULT_FG) dfg_r <= cfg_wdata;
      if (cfg_we && cfg_index == CFG_DEFAULT_BG) dbg_r <= cfg_wdata;
      if (cmd.load_out)    out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_seq_done       = o_done_r;
  assign out_clear_screen   = o_clr_r;
  assign out_cursor_row_out = row_ext[ROW_O_W-1:0];
  assign out_cursor_col_out = col_ext[COL_O_W-1:0];
  assign out_fg_color       = o_fg_r;
  assign out_bg_color       = o_bg_r;

endmodule

[hdl/ansi_csi_cursor_color_parser.sv]
// Top level of the CSI cursor and color parser.
// Depends on acp_pkg, acp_ctrl and acp_dp.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+--------------------------------------
//  in_     | in        | in_valid/in_stall  | ch, seq_start
//  out_    | out       | out_valid/out_stall| seq_done, row, col, fg, bg, clear
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_wdata (3 bit color)
//
// Sequence: each word passes capture, execute and finish; finish waits while
// the output register is held. An SGR with a first parameter present also walks
// its slots one at a time, 1 to MAX_PARAMS, as the slot array has a single read port.
// Reset: synchronous, active low; in_stall is high and cfg_ready low while
// held. Colors reset to defaults 7/0, cursor and saved cursor to 0,0.
// Stalls: the output register holds a finished word while out_stall is high;
// the next input word is accepted meanwhile and waits in the finish state.
module ansi_csi_cursor_color_parser
  import acp_pkg::*;
#(
  parameter int ROWS       = 25,
  parameter int COLS       = 80,
  parameter int MAX_PARAMS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input characters
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CH_W-1:0]      in_ch,
  input  logic                 in_seq_start,
  // results
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_seq_done,
  output logic [ROW_O_W-1:0]   out_cursor_row_out,
  output logic [COL_O_W-1:0]   out_cursor_col_out,
  output logic [COLOR_W-1:0]   out_fg_color,
  output logic [COLOR_W-1:0]   out_bg_color,
  output logic                 out_clear_screen,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_wdata
);

  acp_cmd_t cmd;
  acp_sts_t sts;

  // register writes are always taken; only gated by reset
  assign cfg_ready = rst_n;

  acp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  acp_dp #(
    .ROWS       (ROWS),
    .COLS       (COLS),
    .MAX_PARAMS (MAX_PARAMS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_ch              (in_ch),
    .in_seq_start       (in_seq_start),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_seq_done       (out_seq_done),
    .out_cursor_row_out (out_cursor_row_out),
    .out_cursor_col_out (out_cursor_col_out),
    .out_fg_color       (out_fg_color),
    .out_bg_color       (out_bg_color),
    .out_clear_screen   (out_clear_screen)
  );

endmodule

[hdl/acp_checker.sv]
// Port-level checks for the CSI parser, bound onto the top level.
// Depends on acp_pkg and ansi_csi_cursor_color_parser.
module acp_checker
  import acp_pkg::*;
#(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_seq_done,
  input logic [ROW_O_W-1:0] out_cursor_row_out,
  input logic [COL_O_W-1:0] out_cursor_col_out,
  input logic [COLOR_W-1:0] out_fg_color,
  input logic [COLOR_W-1:0] out_bg_color,
  input logic               out_clear_screen
);

  // held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cursor_row_out)
      && $stable(out_cursor_col_out) && $stable(out_fg_color)
      && $stable(out_bg_color) && $stable(out_seq_done) && $stable(out_clear_screen))
    else $error("result word changed while stalled");

  // one word in flight: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted a word while the previous one is in flight");

  // clear homes the cursor and ends the sequence
  a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clear_screen |->
      out_seq_done && out_cursor_row_out == '0 && out_cursor_col_out == '0)
    else $error("clear without home or sequence end");

  // cursor stays on screen
  a_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(out_cursor_row_out) < ROWS && int'(out_cursor_col_out) < COLS)
    else $error("cursor off screen");

endmodule

bind ansi_csi_cursor_color_parser acp_checker #(
  .ROWS (ROWS),
  .COLS (COLS)
) u_acp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_seq_done       (out_seq_done),
  .out_cursor_row_out (out_cursor_row_out),
  .out_cursor_col_out (out_cursor_col_out),
  .out_fg_color       (out_fg_color),
  .out_bg_color       (out_bg_color),
  .out_clear_screen   (out_clear_screen)
);
